// File: sv/owb_pkg.sv
package owb_pkg;

  localparam int COUNT_WIDTH = 10;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  // one bit wider so the read recovery length (body + 1) fits
  typedef logic [COUNT_WIDTH:0]   len_t;

  localparam cnt_t WRITE_RECOVERY = cnt_t'(4);

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW       = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_PRESENCE_SAMPLE = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL      = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_SLOT_LEAD       = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_WRITE_LOW       = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_SLOT_BODY       = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_READ_LOW        = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE     = REG_IDX_W'(7);

  // reset values of the timing registers
  localparam cnt_t RST_RESET_LOW       = cnt_t'(500);
  localparam cnt_t RST_PRESENCE_SAMPLE = cnt_t'(70);
  localparam cnt_t RST_RESET_TAIL      = cnt_t'(300);
  localparam cnt_t RST_SLOT_LEAD       = cnt_t'(2);
  localparam cnt_t RST_WRITE_LOW       = cnt_t'(10);
  localparam cnt_t RST_SLOT_BODY       = cnt_t'(60);
  localparam cnt_t RST_READ_LOW        = cnt_t'(2);
  localparam cnt_t RST_READ_SAMPLE     = cnt_t'(8);

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_R_LOW   = 11'b000_0000_0010,
    PH_R_WAIT  = 11'b000_0000_0100,
    PH_R_TAIL  = 11'b000_0000_1000,
    PH_LEAD    = 11'b000_0001_0000,
    PH_W_LOW   = 11'b000_0010_0000,
    PH_W_BODY  = 11'b000_0100_0000,
    PH_W_REC   = 11'b000_1000_0000,
    PH_RD_LOW  = 11'b001_0000_0000,
    PH_RD_WAIT = 11'b010_0000_0000,
    PH_RD_BODY = 11'b100_0000_0000
  } phase_t;

  // effective phase lengths, zero already mapped to one where needed
  typedef struct packed {
    len_t reset_low;
    len_t presence_sample;
    len_t reset_tail;
    len_t slot_lead;
    len_t write_low;
    len_t write_body;
    len_t read_low;
    len_t read_sample;
    len_t read_body;
  } phase_len_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       line_in;
  } in_word_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } out_word_t;

endpackage

// File: sv/owb_cfg.sv
module owb_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [owb_pkg::REG_IDX_W-1:0]   cfg_index,
  input  owb_pkg::cnt_t                   cfg_wdata,
  output owb_pkg::phase_len_t             lens
);

  owb_pkg::cnt_t reset_low_r, presence_sample_r, reset_tail_r, slot_lead_r;
  owb_pkg::cnt_t write_low_r, slot_body_r, read_low_r, read_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r       <= owb_pkg::RST_RESET_LOW;
      presence_sample_r <= owb_pkg::RST_PRESENCE_SAMPLE;
      reset_tail_r      <= owb_pkg::RST_RESET_TAIL;
      slot_lead_r       <= owb_pkg::RST_SLOT_LEAD;
      write_low_r       <= owb_pkg::RST_WRITE_LOW;
      slot_body_r       <= owb_pkg::RST_SLOT_BODY;
      read_low_r        <= owb_pkg::RST_READ_LOW;
      read_sample_r     <= owb_pkg::RST_READ_SAMPLE;
    end else if (cfg_we) begin
      case (cfg_index)
        owb_pkg::REG_RESET_LOW:       reset_low_r       <= cfg_wdata;
        owb_pkg::REG_PRESENCE_SAMPLE: presence_sample_r <= cfg_wdata;
        owb_pkg::REG_RESET_TAIL:      reset_tail_r      <= cfg_wdata;
        owb_pkg::REG_SLOT_LEAD:       slot_lead_r       <= cfg_wdata;
        owb_pkg::REG_WRITE_LOW:       write_low_r       <= cfg_wdata;
        owb_pkg::REG_SLOT_BODY:       slot_body_r       <= cfg_wdata;
        owb_pkg::REG_READ_LOW:        read_low_r        <= cfg_wdata;
        owb_pkg::REG_READ_SAMPLE:     read_sample_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero acts as one
  function automatic owb_pkg::len_t min1(input owb_pkg::cnt_t v);
    owb_pkg::len_t r;
    r = {1'b0, v};
    if (v == '0) r = owb_pkg::len_t'(1);
    return r;
  endfunction

  always_comb begin
    lens.reset_low       = min1(reset_low_r);
    lens.presence_sample = min1(presence_sample_r);
    lens.reset_tail      = min1(reset_tail_r);
    lens.slot_lead       = {1'b0, slot_lead_r};
    lens.write_low       = min1(write_low_r);
    lens.write_body      = min1(slot_body_r);
    lens.read_low        = min1(read_low_r);
    lens.read_sample     = min1(read_sample_r);
    lens.read_body       = min1(slot_body_r) + owb_pkg::len_t'(1);
  end

endmodule

// File: sv/owb_seq.sv
module owb_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  owb_pkg::in_word_t   in_word,
  input  owb_pkg::phase_len_t lens,
  output owb_pkg::out_word_t  res
);

  owb_pkg::phase_t phase_r, phase_nxt;
  owb_pkg::op_t    op_r, op_nxt;
  owb_pkg::cnt_t   cnt_r, cnt_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            pres_r, pres_nxt;

  owb_pkg::phase_t ph, low_ph;
  owb_pkg::len_t   len;
  logic            busy, done, drive, rej;
  logic [7:0]      rdata;

  always_comb begin
    ph        = phase_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    busy      = 1'b0;
    done      = 1'b0;
    drive     = 1'b0;
    rej       = 1'b0;
    rdata     = '0;
    len       = owb_pkg::len_t'(1);

    // command start, only when idle
    if (phase_r == owb_pkg::PH_IDLE) begin
      if (in_word.mode != owb_pkg::OP_NONE) begin
        op_nxt  = owb_pkg::op_t'(in_word.mode);
        bit_nxt = '0;
        cnt_nxt = '0;
        if (in_word.mode == owb_pkg::OP_RESET) begin
          shift_nxt = '0;
          ph        = owb_pkg::PH_R_LOW;
        end else begin
          shift_nxt = (in_word.mode == owb_pkg::OP_WRITE) ? in_word.data_byte : 8'h00;
          ph        = owb_pkg::PH_LEAD;
        end
      end
    end else if (in_word.mode != owb_pkg::OP_NONE) begin
      rej = 1'b1;
    end

    low_ph = (op_nxt == owb_pkg::OP_READ) ? owb_pkg::PH_RD_LOW : owb_pkg::PH_W_LOW;
    // no lead ticks: slot opens straight on the low phase
    if (ph == owb_pkg::PH_LEAD && lens.slot_lead == '0 && phase_r == owb_pkg::PH_IDLE)
      ph = low_ph;

    phase_nxt = ph;

    if (ph != owb_pkg::PH_IDLE) begin
      busy = 1'b1;
      case (ph)
        owb_pkg::PH_R_LOW, owb_pkg::PH_W_LOW, owb_pkg::PH_RD_LOW: drive = 1'b1;
        owb_pkg::PH_W_BODY: drive = ~shift_nxt[0];
        default: drive = 1'b0;
      endcase

      case (ph)
        owb_pkg::PH_R_LOW:   len = lens.reset_low;
        owb_pkg::PH_R_WAIT:  len = lens.presence_sample;
        owb_pkg::PH_R_TAIL:  len = lens.reset_tail;
        owb_pkg::PH_LEAD:    len = lens.slot_lead;
        owb_pkg::PH_W_LOW:   len = lens.write_low;
        owb_pkg::PH_W_BODY:  len = lens.write_body;
        owb_pkg::PH_W_REC:   len = {1'b0, owb_pkg::WRITE_RECOVERY};
        owb_pkg::PH_RD_LOW:  len = lens.read_low;
        owb_pkg::PH_RD_WAIT: len = lens.read_sample;
        owb_pkg::PH_RD_BODY: len = lens.read_body;
        default:             len = owb_pkg::len_t'(1);
      endcase

      if (({1'b0, cnt_nxt} + owb_pkg::len_t'(1)) >= len) begin
        cnt_nxt = '0;
        case (ph)
          owb_pkg::PH_R_LOW: phase_nxt = owb_pkg::PH_R_WAIT;
          owb_pkg::PH_R_WAIT: begin
            pres_nxt  = ~in_word.line_in;
            phase_nxt = owb_pkg::PH_R_TAIL;
          end
          owb_pkg::PH_R_TAIL: done = 1'b1;
          owb_pkg::PH_LEAD:   phase_nxt = low_ph;
          owb_pkg::PH_W_LOW:  phase_nxt = owb_pkg::PH_W_BODY;
          owb_pkg::PH_W_BODY: phase_nxt = owb_pkg::PH_W_REC;
          owb_pkg::PH_RD_LOW: phase_nxt = owb_pkg::PH_RD_WAIT;
          owb_pkg::PH_RD_WAIT: begin
            shift_nxt = {in_word.line_in, shift_nxt[7:1]};
            phase_nxt = owb_pkg::PH_RD_BODY;
          end
          owb_pkg::PH_W_REC, owb_pkg::PH_RD_BODY: begin
            if (ph == owb_pkg::PH_W_REC) shift_nxt = {1'b0, shift_nxt[7:1]};
            if (bit_nxt == 3'd7) begin
              done = 1'b1;
            end else begin
              bit_nxt   = bit_nxt + 3'd1;
              phase_nxt = (lens.slot_lead == '0) ? low_ph : owb_pkg::PH_LEAD;
            end
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          if (op_nxt == owb_pkg::OP_READ) rdata = shift_nxt;
          phase_nxt = owb_pkg::PH_IDLE;
          bit_nxt   = '0;
        end
      end else begin
        cnt_nxt = cnt_nxt + owb_pkg::cnt_t'(1);
      end
    end

    res.drive_low = drive;
    res.busy_res  = busy;
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_data = rdata;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owb_pkg::PH_IDLE;
      op_r    <= owb_pkg::OP_NONE;
      cnt_r   <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
    end
  end

endmodule

// File: sv/one_wire_bus_master.sv
// one-wire bus master, tick level. every input word is one bus tick (normally 1 us)
// carrying the sampled line level and, when the master is idle, an optional command:
// reset/presence, write byte or read byte (bytes go lsb first). every input word
// yields exactly one output word with the pin drive for that tick, busy/done flags,
// the latest presence result, the read byte on the done tick of a read, and a
// rejected flag for a command sent while busy. one word is taken per clock cycle
// whenever the output register is free or being drained in the same cycle, so the
// block runs at one tick per cycle; a tick's result is registered in the output register
// in the cycle after the word is accepted. the user must write the eight timing registers
// through the cfg port only while no operation is running; the block does not enforce it.
module one_wire_bus_master (
  input  logic                           clk,
  input  logic                           rst_n,
  // tick input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  owb_pkg::in_word_t              in_data,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output owb_pkg::out_word_t             out_data,
  // timing registers
  input  logic                           cfg_we,
  input  logic [owb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  owb_pkg::cnt_t                  cfg_wdata
);

  owb_pkg::phase_len_t lens;
  owb_pkg::out_word_t  res;
  owb_pkg::out_word_t  out_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  // a new word goes in whenever the output register frees up this cycle
  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  // timing register file and effective phase lengths
  owb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .lens      (lens)
  );

  // bus sequencer, advances one tick per accepted word
  owb_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .in_word (in_data),
    .lens    (lens),
    .res     (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept)         out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
